[rtl/core/kcl_pkg.sv]
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants for the keypad combination lock
// Payload structs, sequencer state codes, key codes and register indexes.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int unsigned NUM_KEYS = 16;

    // Key codes
    localparam logic [4:0] KEY_NONE = 5'd0;
    localparam logic [4:0] KEY_MANY = 5'd17;

    // Register indexes
    localparam logic [2:0] CFG_LEAD_KEY    = 3'd0;
    localparam logic [2:0] CFG_DIGIT_ONE   = 3'd1;
    localparam logic [2:0] CFG_DIGIT_TWO   = 3'd2;
    localparam logic [2:0] CFG_DIGIT_THREE = 3'd3;
    localparam logic [2:0] CFG_DIGIT_FOUR  = 3'd4;
    localparam logic [2:0] CFG_DIGIT_FIVE  = 3'd5;

    // Register reset values ('#', '1', '2', '3', '4', '5')
    localparam logic [3:0] RST_LEAD_KEY    = 4'd14;
    localparam logic [3:0] RST_DIGIT_ONE   = 4'd0;
    localparam logic [3:0] RST_DIGIT_TWO   = 4'd1;
    localparam logic [3:0] RST_DIGIT_THREE = 4'd2;
    localparam logic [3:0] RST_DIGIT_FOUR  = 4'd4;
    localparam logic [3:0] RST_DIGIT_FIVE  = 4'd5;

    // Reported step codes
    localparam logic [3:0] STEP_START    = 4'd0;
    localparam logic [3:0] STEP_IDLE     = 4'd1;
    localparam logic [3:0] STEP_UNLOCKED = 4'd2;
    localparam logic [3:0] STEP_LEAD_P   = 4'd3;
    localparam logic [3:0] STEP_LEAD_H   = 4'd4;
    localparam logic [3:0] STEP_D1_P     = 4'd5;
    localparam logic [3:0] STEP_D1_H     = 4'd6;
    localparam logic [3:0] STEP_D2_P     = 4'd7;
    localparam logic [3:0] STEP_D2_H     = 4'd8;
    localparam logic [3:0] STEP_D3_P     = 4'd9;
    localparam logic [3:0] STEP_D3_H     = 4'd10;
    localparam logic [3:0] STEP_D4_P     = 4'd11;
    localparam logic [3:0] STEP_D4_H     = 4'd12;

    typedef enum logic [12:0] {
        ST_START    = 13'b0000000000001,
        ST_IDLE     = 13'b0000000000010,
        ST_UNLOCKED = 13'b0000000000100,
        ST_LEAD_P   = 13'b0000000001000,
        ST_LEAD_H   = 13'b0000000010000,
        ST_D1_P     = 13'b0000000100000,
        ST_D1_H     = 13'b0000001000000,
        ST_D2_P     = 13'b0000010000000,
        ST_D2_H     = 13'b0000100000000,
        ST_D3_P     = 13'b0001000000000,
        ST_D3_H     = 13'b0010000000000,
        ST_D4_P     = 13'b0100000000000,
        ST_D4_H     = 13'b1000000000000
    } kcl_state_t;

    typedef struct packed {
        logic [15:0] keys_down;
        logic        lock_button;
    } kcl_in_t;

    typedef struct packed {
        logic       unlocked;
        logic [4:0] key_code;
        logic [3:0] lock_step;
    } kcl_out_t;

    typedef struct packed {
        logic [3:0] lead_key;
        logic [3:0] digit_one;
        logic [3:0] digit_two;
        logic [3:0] digit_three;
        logic [3:0] digit_four;
        logic [3:0] digit_five;
    } kcl_cfg_t;

    typedef struct packed {
        logic       none;
        logic       single;
        logic [3:0] pos;
        logic [4:0] code;
    } kcl_key_t;

    function automatic logic [3:0] step_code(kcl_state_t st);
        logic [3:0] code;
        unique case (st)
            ST_START:    code = STEP_START;
            ST_IDLE:     code = STEP_IDLE;
            ST_UNLOCKED: code = STEP_UNLOCKED;
            ST_LEAD_P:   code = STEP_LEAD_P;
            ST_LEAD_H:   code = STEP_LEAD_H;
            ST_D1_P:     code = STEP_D1_P;
            ST_D1_H:     code = STEP_D1_H;
            ST_D2_P:     code = STEP_D2_P;
            ST_D2_H:     code = STEP_D2_H;
            ST_D3_P:     code = STEP_D3_P;
            ST_D3_H:     code = STEP_D3_H;
            ST_D4_P:     code = STEP_D4_P;
            ST_D4_H:     code = STEP_D4_H;
            default:     code = STEP_START;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/keypad_combination_lock_top.sv]
// ----------------------------------------------------------------------------
// keypad_combination_lock_top: keypad combination lock
// Input register, key decode and sequencer step, result register.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_stall/in_data): one sampled key vector and lock
//               button per request.
//   out channel (out_valid/out_stall/out_data): one result per request with
//               the open flag, decoded key code and sequencer step.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the lead key
//               (index 0) and digits one to five (1..5); cfg_ready is always
//               high, other indexes are dropped. Write only while idle.
// Order: a request passes the input register, then the result register.
// Throughput: one request per cycle while the result is not stalled, set by
//   the combinational sequencer step between the two registers.
// Reset: sequencer goes to its start step with the lock closed, registers
//   return to the code #12345, both pipeline stages empty.
// Stall: a stalled result holds; the input register still fills behind it,
//   and in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module keypad_combination_lock_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  kcl_pkg::kcl_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output kcl_pkg::kcl_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [3:0]        cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    kcl_pkg::kcl_in_t  in_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    kcl_pkg::kcl_out_t out_data_reg;
    kcl_pkg::kcl_out_t out_data_next;

    logic              load;
    logic              advance;
    kcl_pkg::kcl_cfg_t cfg;
    kcl_pkg::kcl_key_t key;
    logic              unlocked_next;
    logic [3:0]        step_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign load      = in_valid && !in_stall;

    kcl_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kcl_keydec u_keydec (
        .keys_down (in_data_reg.keys_down),
        .key       (key)
    );

    kcl_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (advance),
        .lock_button   (in_data_reg.lock_button),
        .key           (key),
        .cfg           (cfg),
        .unlocked_next (unlocked_next),
        .step_next     (step_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_data_next.unlocked  = unlocked_next;
        out_data_next.key_code  = key.code;
        out_data_next.lock_step = step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_advance_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("sequencer step produced no result");

endmodule

[rtl/core/kcl_cfg.sv]
// ----------------------------------------------------------------------------
// kcl_cfg: code registers
// Holds the lead key and the five code digits; writes beyond the list drop.
// ----------------------------------------------------------------------------
module kcl_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [3:0]       wr_data,
    output kcl_pkg::kcl_cfg_t cfg
);

    kcl_pkg::kcl_cfg_t cfg_reg;
    kcl_pkg::kcl_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                kcl_pkg::CFG_LEAD_KEY:    cfg_next.lead_key    = wr_data;
                kcl_pkg::CFG_DIGIT_ONE:   cfg_next.digit_one   = wr_data;
                kcl_pkg::CFG_DIGIT_TWO:   cfg_next.digit_two   = wr_data;
                kcl_pkg::CFG_DIGIT_THREE: cfg_next.digit_three = wr_data;
                kcl_pkg::CFG_DIGIT_FOUR:  cfg_next.digit_four  = wr_data;
                kcl_pkg::CFG_DIGIT_FIVE:  cfg_next.digit_five  = wr_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead_key    <= kcl_pkg::RST_LEAD_KEY;
            cfg_reg.digit_one   <= kcl_pkg::RST_DIGIT_ONE;
            cfg_reg.digit_two   <= kcl_pkg::RST_DIGIT_TWO;
            cfg_reg.digit_three <= kcl_pkg::RST_DIGIT_THREE;
            cfg_reg.digit_four  <= kcl_pkg::RST_DIGIT_FOUR;
            cfg_reg.digit_five  <= kcl_pkg::RST_DIGIT_FIVE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/kcl_keydec.sv]
// ----------------------------------------------------------------------------
// kcl_keydec: key matrix decoder
// Reduces the 16-bit key vector to none, one key position, or several keys.
// ----------------------------------------------------------------------------
module kcl_keydec (
    input  logic [15:0]       keys_down,
    output kcl_pkg::kcl_key_t key
);

    logic [3:0] pos;
    logic       none;
    logic       single;

    always_comb
    begin
        pos = 4'd0;
        for (int i = 0; i < kcl_pkg::NUM_KEYS; i++)
        begin
            if (keys_down[i])
            begin
                pos = pos | 4'(i);
            end
        end
    end

    assign none   = (keys_down == 16'd0);
    // exactly one bit set: clearing the lowest set bit leaves nothing
    assign single = !none && ((keys_down & (keys_down - 16'd1)) == 16'd0);

    always_comb
    begin
        key.none   = none;
        key.single = single;
        key.pos    = pos;
        if (none)
        begin
            key.code = kcl_pkg::KEY_NONE;
        end
        else if (single)
        begin
            key.code = {1'b0, pos} + 5'd1;
        end
        else
        begin
            key.code = kcl_pkg::KEY_MANY;
        end
    end

endmodule

[rtl/core/kcl_seq.sv]
// ----------------------------------------------------------------------------
// kcl_seq: code sequencer
// Steps through lead key and code digits; holds the open flag.
// ----------------------------------------------------------------------------
module kcl_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              lock_button,
    input  kcl_pkg::kcl_key_t key,
    input  kcl_pkg::kcl_cfg_t cfg,
    output logic              unlocked_next,
    output logic [3:0]        step_next
);

    kcl_pkg::kcl_state_t state_reg;
    kcl_pkg::kcl_state_t state_next;
    logic                open_reg;
    logic                open_next;

    logic is_lead;
    logic is_d1;
    logic is_d2;
    logic is_d3;
    logic is_d4;
    logic is_d5;

    assign is_lead = key.single && (key.pos == cfg.lead_key);
    assign is_d1   = key.single && (key.pos == cfg.digit_one);
    assign is_d2   = key.single && (key.pos == cfg.digit_two);
    assign is_d3   = key.single && (key.pos == cfg.digit_three);
    assign is_d4   = key.single && (key.pos == cfg.digit_four);
    assign is_d5   = key.single && (key.pos == cfg.digit_five);

    // order: lead key, then no key or the held digit, then the next digit
    always_comb
    begin
        unique case (state_reg)
            kcl_pkg::ST_START:
                state_next = kcl_pkg::ST_IDLE;
            kcl_pkg::ST_IDLE:
                state_next = is_lead ? kcl_pkg::ST_LEAD_P : kcl_pkg::ST_IDLE;
            kcl_pkg::ST_UNLOCKED:
                state_next = lock_button ? kcl_pkg::ST_IDLE : kcl_pkg::ST_UNLOCKED;
            kcl_pkg::ST_LEAD_P:
                state_next = (key.none || is_lead) ? kcl_pkg::ST_LEAD_H
                                                   : kcl_pkg::ST_IDLE;
            kcl_pkg::ST_LEAD_H:
            begin
                priority if (is_lead || key.none) state_next = kcl_pkg::ST_LEAD_H;
                else if (is_d1)                   state_next = kcl_pkg::ST_D1_P;
                else                              state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D1_P:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d1)     state_next = kcl_pkg::ST_D1_H;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D1_H:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d1)     state_next = kcl_pkg::ST_D1_H;
                else if (is_d2)                 state_next = kcl_pkg::ST_D2_P;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D2_P:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d2)     state_next = kcl_pkg::ST_D2_H;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D2_H:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d2)     state_next = kcl_pkg::ST_D2_H;
                else if (is_d3)                 state_next = kcl_pkg::ST_D3_P;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D3_P:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d3)     state_next = kcl_pkg::ST_D3_H;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D3_H:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d3)     state_next = kcl_pkg::ST_D3_H;
                else if (is_d4)                 state_next = kcl_pkg::ST_D4_P;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D4_P:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d4)     state_next = kcl_pkg::ST_D4_H;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            kcl_pkg::ST_D4_H:
            begin
                priority if (is_lead)           state_next = kcl_pkg::ST_LEAD_P;
                else if (key.none || is_d4)     state_next = kcl_pkg::ST_D4_H;
                else if (is_d5)                 state_next = kcl_pkg::ST_UNLOCKED;
                else                            state_next = kcl_pkg::ST_IDLE;
            end
            default:
                state_next = kcl_pkg::ST_START;
        endcase
    end

    // start step keeps the flag; every other step sets or clears it
    always_comb
    begin
        if (state_next == kcl_pkg::ST_UNLOCKED)
        begin
            open_next = 1'b1;
        end
        else if (state_next != kcl_pkg::ST_START)
        begin
            open_next = 1'b0;
        end
        else
        begin
            open_next = open_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kcl_pkg::ST_START;
            open_reg  <= 1'b0;
        end
        else if (enable)
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
        end
    end

    assign unlocked_next = open_next;
    assign step_next     = kcl_pkg::step_code(state_next);

    a_open_matches_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        open_reg == (state_reg == kcl_pkg::ST_UNLOCKED))
        else $error("open flag disagrees with sequencer state");

    a_unlocked_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (enable && state_reg == kcl_pkg::ST_UNLOCKED && !lock_button)
        |=> (state_reg == kcl_pkg::ST_UNLOCKED))
        else $error("lock closed without lock button");

    a_start_to_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (enable && state_reg == kcl_pkg::ST_START) |=> (state_reg == kcl_pkg::ST_IDLE))
        else $error("start step did not advance to idle");

endmodule
